>>> rtl/core/vse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vse_pkg
// Shared types and constants for the vector similarity engine.
// ----------------------------------------------------------------------------
package vse_pkg;

	localparam int unsigned MAX_DIM_DEF    = 4096;
	localparam int unsigned ELEM_WIDTH_DEF = 16;
	localparam int unsigned ACC_W          = 48;
	localparam int unsigned ABS_W          = 32;
	localparam int unsigned CNT_W          = 17;
	localparam int unsigned ROOT_W         = 24;

	typedef enum logic [1:0] {
		MODE_DOT    = 2'd0,
		MODE_COSINE = 2'd1,
		MODE_EUCLID = 2'd2,
		MODE_MANH   = 2'd3
	} mode_t;

	// one-hot sequencer states
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL   = 8'b0000_0010,
		ST_ACC   = 8'b0000_0100,
		ST_SQRT  = 8'b0000_1000,
		ST_DMUL  = 8'b0001_0000,
		ST_DIV   = 8'b0010_0000,
		ST_FIN   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

endpackage

>>> rtl/core/vse_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vse_sqrt
// Bit-serial floor square root of a 48-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vse_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vse_pkg::ACC_W-1:0]    radicand,
	output logic                         busy,
	output logic [vse_pkg::ROOT_W-1:0]   root
);
	import vse_pkg::*;

	localparam int unsigned STEP_W = $clog2(ROOT_W + 1);

	logic [ACC_W-1:0]  rem_q;
	logic [ACC_W-1:0]  x_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [ACC_W+1:0]  trial;
	logic [ACC_W+1:0]  rem_sh;

	// restoring method: bring down two bits, try (root<<2)|1
	always_comb begin
		rem_sh = {rem_q, x_q[ACC_W-1 -: 2]};
		trial  = rem_sh - {{(ACC_W-ROOT_W){1'b0}}, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(ROOT_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			x_q    <= radicand;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[ACC_W-3:0], 2'b00};
			if (!trial[ACC_W+1]) begin
				rem_q  <= trial[ACC_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[ACC_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && busy_q)) else $error("sqrt started while busy");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(ROOT_W));
	a_busy_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q != '0));

endmodule

>>> rtl/core/vse_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vse_div
// Restoring divider, unsigned 64 / 48, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vse_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [63:0]               dividend,
	input  logic [vse_pkg::ACC_W-1:0] divisor,
	output logic                      busy,
	output logic [63:0]               quotient
);
	import vse_pkg::*;

	logic [63:0]      q_q;
	logic [ACC_W:0]   rem_q;
	logic [ACC_W-1:0] d_q;
	logic [6:0]       step_q;
	logic             busy_q;
	logic [ACC_W:0]   rem_sh;
	logic [ACC_W+1:0] diff;

	always_comb begin
		rem_sh = {rem_q[ACC_W-1:0], q_q[63]};
		diff   = {1'b0, rem_sh} - {2'b00, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 7'd64;
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == 7'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			if (!diff[ACC_W+1]) begin
				rem_q <= diff[ACC_W:0];
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = q_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && busy_q)) else $error("divider started while busy");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 7'd64);
	a_busy_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q != '0));

endmodule

>>> rtl/core/vector_similarity_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_similarity_engine
// Streaming dot / cosine / euclidean / manhattan metric over element pairs.
// ----------------------------------------------------------------------------
// One element pair is taken per beat; one shared 32x32 multiplier forms the
// four products a*b, a*a, b*b and (a-b)^2 in turn. On a final pair the metric
// is formed: dot and manhattan take their accumulated sum as the result,
// euclidean adds a bit-serial square root, and cosine adds two square roots,
// a product of the roots and a divider. The input is not ready while an item
// is in work; the result waits in an output register until taken. Pairs
// beyond MAX_DIM are dropped and flagged on the result's overflow bit.
module vector_similarity_engine #(
	parameter int unsigned MAX_DIM    = vse_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [15:0]           elem_a,
	input  logic signed [15:0]           elem_b,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [47:0]           result,
	output logic                         overflow
);
	import vse_pkg::*;

	localparam int unsigned EW  = ELEM_WIDTH_DEF;
	localparam int unsigned MW  = 32;

	state_t            state_q;
	mode_t             mode_q;
	logic [ACC_W-1:0]  dot_q, na_q, nb_q, dsq_q;
	logic [ABS_W-1:0]  abs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic              last_q;
	logic signed [16:0] a_q, b_q, d_q;
	logic [1:0]        op_q;
	logic [ROOT_W-1:0] ra_q;
	logic              sq_phase_q;
	logic [47:0]       res_q;
	logic              ovfo_q;
	logic              outv_q;

	logic signed [MW-1:0] mul_x, mul_y;
	logic [2*MW-1:0]      mul_p;
	logic [16:0]          ad;
	logic                 sq_start, sq_busy;
	logic                 dv_start, dv_busy;
	logic [ACC_W-1:0]     sq_in;
	logic [ROOT_W-1:0]    sq_root;
	logic [63:0]          dv_q;
	logic                 dot_neg;
	logic [ACC_W-1:0]     dot_mag;

	assign dot_neg = dot_q[ACC_W-1];
	assign dot_mag = dot_neg ? (~dot_q + 1'b1) : dot_q;
	assign ad      = d_q[16] ? 17'(-d_q) : 17'(d_q);

	// shared multiplier operand select
	always_comb begin
		case (op_q)
			2'd0:    begin mul_x = MW'(a_q); mul_y = MW'(b_q); end
			2'd1:    begin mul_x = MW'(a_q); mul_y = MW'(a_q); end
			2'd2:    begin mul_x = MW'(b_q); mul_y = MW'(b_q); end
			default: begin mul_x = MW'(d_q); mul_y = MW'(d_q); end
		endcase
		if (state_q == ST_DMUL) begin
			mul_x = MW'(ra_q);
			mul_y = MW'(sq_root);
		end
	end
	assign mul_p = (2*MW)'(mul_x) * (2*MW)'(mul_y);

	assign in_ready  = (state_q == ST_IDLE) && !outv_q;
	assign cfg_ready = (state_q == ST_IDLE) && !outv_q;

	// first root (norm a) starts from ACC, second (norm b) from SQRT
	assign sq_in = (mode_q == MODE_EUCLID) ? dsq_q :
		((state_q == ST_SQRT) ? nb_q : na_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_DOT;
			dot_q      <= '0;
			na_q       <= '0;
			nb_q       <= '0;
			dsq_q      <= '0;
			abs_q      <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			outv_q     <= 1'b0;
			op_q       <= '0;
			sq_phase_q <= 1'b0;
			ra_q       <= '0;
			res_q      <= '0;
			ovfo_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_q <= mode_t'(cfg_data);
			if (out_valid && out_ready)
				outv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (cnt_q >= CNT_W'(MAX_DIM)) begin
							ovf_q   <= 1'b1;
							state_q <= last ? ST_ACC : ST_IDLE;
							op_q    <= 2'd3;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							op_q    <= 2'd0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					case (op_q)
						2'd0: begin
							dot_q <= dot_q + mul_p[ACC_W-1:0];
							abs_q <= abs_q + ABS_W'(ad);
						end
						2'd1:    na_q  <= na_q + mul_p[ACC_W-1:0];
						2'd2:    nb_q  <= nb_q + mul_p[ACC_W-1:0];
						default: dsq_q <= dsq_q + mul_p[ACC_W-1:0];
					endcase
					op_q <= op_q + 1'b1;
					if (op_q == 2'd3)
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else begin
						case (mode_q)
							MODE_DOT: begin
								res_q   <= dot_q;
								state_q <= ST_OUT;
							end
							MODE_MANH: begin
								res_q   <= 48'(abs_q);
								state_q <= ST_OUT;
							end
							default: begin
								sq_phase_q <= 1'b0;
								state_q    <= ST_SQRT;
							end
						endcase
					end
				end
				ST_SQRT: begin
					if (!sq_busy) begin
						if (mode_q == MODE_EUCLID) begin
							res_q   <= 48'(sq_root);
							state_q <= ST_OUT;
						end else if (!sq_phase_q) begin
							ra_q       <= sq_root;
							sq_phase_q <= 1'b1;
						end else begin
							state_q <= ST_DMUL;
						end
					end
				end
				ST_DMUL: begin
					if (ra_q == '0 || sq_root == '0) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!dv_busy)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (dot_neg)
						res_q <= (dv_q > 64'd32768) ? -48'sd32768 : 48'(-$signed(dv_q));
					else
						res_q <= (dv_q > 64'd32767) ? 48'sd32767 : 48'(dv_q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					outv_q  <= 1'b1;
					ovfo_q  <= ovf_q;
					dot_q   <= '0;
					na_q    <= '0;
					nb_q    <= '0;
					dsq_q   <= '0;
					abs_q   <= '0;
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			a_q    <= 17'($signed(EW'(elem_a)));
			b_q    <= 17'($signed(EW'(elem_b)));
			d_q    <= 17'($signed(EW'(elem_a))) - 17'($signed(EW'(elem_b)));
			last_q <= last;
		end
	end

	always_comb begin
		sq_start = 1'b0;
		if (state_q == ST_ACC && last_q &&
		    (mode_q == MODE_COSINE || mode_q == MODE_EUCLID))
			sq_start = 1'b1;
		if (state_q == ST_SQRT && !sq_busy && !sq_phase_q &&
		    mode_q == MODE_COSINE)
			sq_start = 1'b1;
	end

	vse_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.radicand(sq_in), .busy(sq_busy), .root(sq_root)
	);

	assign dv_start = (state_q == ST_DMUL) && (ra_q != '0) && (sq_root != '0);

	vse_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend({1'b0, dot_mag, 15'd0}), .divisor(mul_p[ACC_W-1:0]),
		.busy(dv_busy), .quotient(dv_q)
	);

	assign out_valid = outv_q;
	assign result    = res_q;
	assign overflow  = ovfo_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE)) else $error("input ready outside idle");
	a_ready_pending: assert property (@(posedge clk) disable iff (!arst_n)
		outv_q |-> !in_ready) else $error("input ready while result pending");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIM)) else $error("pair count beyond MAX_DIM");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));

endmodule
